### hw/rtl/dvrt_pkg.sv
// Shared types and constants for the distance-vector route table.
// Holds field widths, command and register codes, and the table entry structs.
// No dependencies.
package dvrt_pkg;

  localparam int NODES_DEF = 256;
  localparam int PORTS_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 8;
  localparam int PORT_W  = 4;
  localparam int COST_W  = 16;
  localparam int PCNT_W  = 5;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

  localparam logic [CFGI_W-1:0] CFG_OWN_ID   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_INF_COST = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_PORT_CNT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   nbr_id;
    logic [PORT_W-1:0] in_port;
    logic [ID_W-1:0]   dest_id;
    logic [COST_W-1:0] cost;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   hop_id;
    logic [PORT_W-1:0] port;
  } route_t;

  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] cost;
  } nbr_t;

  typedef struct packed {
    logic [ID_W-1:0]   own_id;
    logic [COST_W-1:0] inf_cost;
    logic [PCNT_W-1:0] port_cnt;
  } cfg_t;

  typedef struct packed {
    logic              rt_we;
    route_t            rt_wdata;
    logic              nb_we;
    nbr_t              nb_wdata;
    logic              advertise;
    logic              deliver_local;
    logic              forward;
    logic [PORT_W-1:0] egress_port;
  } eval_t;

endpackage

### hw/rtl/dvrt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package needed.
module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/dvrt_eval.sv
// Event evaluation: decides table updates and lookup answers for one event.
// Works on the entries read from the route and neighbor memories; uses dvrt_pkg.
module dvrt_eval #(
  parameter int NODES = dvrt_pkg::NODES_DEF,
  parameter int PORTS = dvrt_pkg::PORTS_DEF
) (
  input  dvrt_pkg::item_t  item_i,
  input  dvrt_pkg::route_t rt_i,
  input  dvrt_pkg::nbr_t   nb_i,
  input  dvrt_pkg::cfg_t   cfg_i,
  output dvrt_pkg::eval_t  ev_o
);
  import dvrt_pkg::*;

  logic              n_ok, d_ok, p_ok;
  logic              inf_adv, sat, nchg, own_hop;
  logic [COST_W:0]   sum;
  route_t            direct_rt, adv_rt;

  assign n_ok    = 32'(item_i.nbr_id) < 32'(NODES);
  assign d_ok    = 32'(item_i.dest_id) < 32'(NODES);
  assign p_ok    = 32'(item_i.in_port) < 32'(PORTS);
  assign inf_adv = item_i.cost >= cfg_i.inf_cost;
  assign sum     = {1'b0, item_i.cost} + {1'b0, nb_i.cost};
  // a sum at or past infinity is saturated and never installs anything
  assign sat     = sum >= {1'b0, cfg_i.inf_cost};
  assign nchg    = !nb_i.valid || (nb_i.cost != item_i.cost);
  assign own_hop = rt_i.hop_id == item_i.nbr_id;

  assign direct_rt = '{valid: 1'b1, cost: item_i.cost, hop_id: item_i.nbr_id,
                       port: item_i.in_port};
  assign adv_rt    = '{valid: 1'b1, cost: sum[COST_W-1:0], hop_id: item_i.nbr_id,
                       port: item_i.in_port};

  always_comb begin
    ev_o = '0;
    case (item_i.command)
      CMD_REPORT: begin
        if (n_ok && p_ok) begin
          ev_o.nb_we    = 1'b1;
          ev_o.nb_wdata = '{valid: 1'b1, cost: item_i.cost};
          if (nb_i.valid) begin
            if (rt_i.valid && own_hop) begin
              if (nchg) begin
                ev_o.rt_we         = 1'b1;
                ev_o.rt_wdata      = rt_i;
                ev_o.rt_wdata.cost = item_i.cost;
                ev_o.advertise     = 1'b1;
              end
            end else if (!rt_i.valid || rt_i.cost == '0 || rt_i.cost > item_i.cost) begin
              ev_o.rt_we     = 1'b1;
              ev_o.rt_wdata  = direct_rt;
              ev_o.advertise = 1'b1;
            end
          end else if (!rt_i.valid || rt_i.cost > item_i.cost) begin
            ev_o.rt_we     = 1'b1;
            ev_o.rt_wdata  = direct_rt;
            ev_o.advertise = 1'b1;
          end
        end
      end
      CMD_ADVERT: begin
        if (n_ok && d_ok && p_ok && nb_i.valid) begin
          if (!rt_i.valid) begin
            if (!inf_adv && item_i.dest_id != cfg_i.own_id && !sat) begin
              ev_o.rt_we     = 1'b1;
              ev_o.rt_wdata  = adv_rt;
              ev_o.advertise = 1'b1;
            end
          end else if (inf_adv) begin
            // withdraw only a route learned from this advertiser
            if (own_hop) begin
              ev_o.rt_we     = 1'b1;
              ev_o.rt_wdata  = '0;
              ev_o.advertise = 1'b1;
            end
          end else if (!sat && sum[COST_W-1:0] < rt_i.cost) begin
            ev_o.rt_we     = 1'b1;
            ev_o.rt_wdata  = adv_rt;
            ev_o.advertise = 1'b1;
          end
        end
      end
      CMD_LOOKUP: begin
        if (item_i.dest_id == cfg_i.own_id) begin
          ev_o.deliver_local = 1'b1;
        end else if (d_ok && rt_i.valid && {1'b0, rt_i.port} < cfg_i.port_cnt) begin
          ev_o.forward     = 1'b1;
          ev_o.egress_port = rt_i.port;
        end
      end
      default: begin
        // neighbor down with an unknown id changes nothing
      end
    endcase
  end

endmodule

### hw/rtl/distance_vector_route_table.sv
// Distance-vector route table: top level with control sequencer, memories and output register.
// Uses dvrt_pkg, dvrt_ram and dvrt_eval.
//
// Route and neighbor tables live in two synchronous RAMs indexed by node id. After reset a
// clearing pass writes zeros to every entry, one entry a cycle; no beat is taken during the
// pass (configuration writes work throughout). A cost report, advert entry or lookup first
// reads the route and neighbor entries, then evaluates, writes back and loads the result.
// A neighbor-down event sweeps the whole route memory through its single read port and then
// clears the neighbor entry. One event is in flight at a time; a new beat is taken while the
// block is idle and the output register is empty or being drained.
// Input tdata, from bit 0: command[1:0], nbr_id[9:2], in_port[13:10], dest_id[21:14],
// cost[37:22], zero fill. tlast carries last_entry.
module distance_vector_route_table #(
  parameter int NODES = dvrt_pkg::NODES_DEF,
  parameter int PORTS = dvrt_pkg::PORTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dvrt_pkg::CFGI_W-1:0]        cfg_idx_i,
  input  logic [dvrt_pkg::CFGD_W-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // command, nbr_id, in_port, dest_id, cost, zero fill
  input  logic [dvrt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // advertise, round_changed, deliver_local, forward, egress_port[7:4]
  output logic [dvrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import dvrt_pkg::*;

  localparam int IdxW = $clog2(NODES);
  localparam int CntW = $clog2(NODES + 1);
  localparam int RtW  = $bits(route_t);
  localparam int NbW  = $bits(nbr_t);
  localparam logic [CntW-1:0] CntEnd  = CntW'(NODES);
  localparam logic [CntW-1:0] CntLast = CntW'(NODES - 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_WALK = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]        rd_addr_q;
  logic                   chg_q, chg_d;
  logic                   pend_q, pend_d;
  cfg_t                   cfg_q;
  item_t                  item_q, in_item;
  logic                   last_q;
  logic                   out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   in_acc, load;
  logic                   walk_issue, walk_hit;
  logic                   rnd;

  logic                   rt_we, nb_we;
  logic [IdxW-1:0]        rt_waddr, rt_raddr, nb_waddr, nb_raddr;
  route_t                 rt_wdata, rt_rd;
  nbr_t                   nb_wdata, nb_rd;
  eval_t                  ev;

  assign in_item = '{command:     s_axis_tdata[1:0],
                     nbr_id:      s_axis_tdata[9:2],
                     in_port:     s_axis_tdata[13:10],
                     dest_id:     s_axis_tdata[21:14],
                     cost:        s_axis_tdata[37:22]};

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_vld_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{own_id: '0, inf_cost: '1, port_cnt: PCNT_W'(16)};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ID:   cfg_q.own_id   <= cfg_data_i[ID_W-1:0];
        CFG_INF_COST: cfg_q.inf_cost <= cfg_data_i[COST_W-1:0];
        CFG_PORT_CNT: cfg_q.port_cnt <= cfg_data_i[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  dvrt_ram #(.WIDTH(RtW), .DEPTH(NODES)) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .raddr_i (rt_raddr),
    .rdata_o (rt_rd)
  );

  dvrt_ram #(.WIDTH(NbW), .DEPTH(NODES)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nb_we),
    .waddr_i (nb_waddr),
    .wdata_i (nb_wdata),
    .raddr_i (nb_raddr),
    .rdata_o (nb_rd)
  );

  dvrt_eval #(.NODES(NODES), .PORTS(PORTS)) u_eval (
    .item_i (item_q),
    .rt_i   (rt_rd),
    .nb_i   (nb_rd),
    .cfg_i  (cfg_q),
    .ev_o   (ev)
  );

  assign walk_issue = cnt_q != CntEnd;
  assign walk_hit   = rd_vld_q && rt_rd.valid && (rt_rd.hop_id == item_q.nbr_id);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    chg_d      = chg_q;
    pend_d     = pend_q;
    load       = 1'b0;
    out_data_d = out_data_q;
    rnd        = 1'b0;

    rt_we      = 1'b0;
    rt_waddr   = (item_q.command == CMD_REPORT) ? IdxW'(item_q.nbr_id)
                                                : IdxW'(item_q.dest_id);
    rt_wdata   = ev.rt_wdata;
    nb_we      = 1'b0;
    nb_waddr   = IdxW'(item_q.nbr_id);
    nb_wdata   = ev.nb_wdata;
    rt_raddr   = (in_item.command == CMD_REPORT) ? IdxW'(in_item.nbr_id)
                                                 : IdxW'(in_item.dest_id);
    nb_raddr   = IdxW'(in_item.nbr_id);

    case (state_q)
      ST_CLR: begin
        rt_we    = 1'b1;
        rt_waddr = cnt_q[IdxW-1:0];
        rt_wdata = '0;
        nb_we    = 1'b1;
        nb_waddr = cnt_q[IdxW-1:0];
        nb_wdata = '0;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.command == CMD_DOWN && 32'(in_item.nbr_id) < 32'(NODES)) begin
            state_d = ST_WALK;
            cnt_d   = '0;
            chg_d   = 1'b0;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        rt_we = ev.rt_we;
        nb_we = ev.nb_we;
        if (item_q.command == CMD_ADVERT) begin
          if (last_q) begin
            rnd    = pend_q | ev.advertise;
            pend_d = 1'b0;
          end else begin
            pend_d = pend_q | ev.advertise;
          end
        end
        load       = 1'b1;
        out_data_d = {ev.egress_port, ev.forward, ev.deliver_local, rnd, ev.advertise};
        state_d    = ST_IDLE;
      end
      ST_WALK: begin
        // read the next entry while the previous one is checked and dropped
        rt_raddr = cnt_q[IdxW-1:0];
        rd_vld_d = walk_issue;
        if (walk_issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        rt_we    = walk_hit;
        rt_waddr = rd_addr_q;
        rt_wdata = '0;
        chg_d    = chg_q | walk_hit;
        if (!walk_issue) begin
          nb_we      = 1'b1;
          nb_wdata   = '0;
          load       = 1'b1;
          out_data_d = {{(OUT_TDATA_W-1){1'b0}}, chg_q | walk_hit};
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      chg_q     <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      chg_q     <= chg_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item;
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_WALK) begin
      rd_addr_q <= cnt_q[IdxW-1:0];
    end
    out_data_q <= out_data_d;
  end

`ifndef SYNTHESIS
  a_exec_yields_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> m_axis_tvalid)
    else $error("evaluated event produced no result beat");

  a_walk_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q <= CntEnd))
    else $error("neighbor-down sweep ran past the table");

  a_idle_no_route_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rt_we)
    else $error("route memory written while idle");
`endif

endmodule
